// ----- rtl/chgw_pkg.sv -----
package chgw_pkg;

    // Controller states, one flip-flop per state.
    typedef enum logic [10:0] {
        S_LOAD  = 11'b000_0000_0001,
        S_LEFT  = 11'b000_0000_0010,
        S_FEW   = 11'b000_0000_0100,
        S_QRD   = 11'b000_0000_1000,
        S_QWAIT = 11'b000_0001_0000,
        S_RRD   = 11'b000_0010_0000,
        S_DIF   = 11'b000_0100_0000,
        S_MUL1  = 11'b000_1000_0000,
        S_MUL2  = 11'b001_0000_0000,
        S_CMP   = 11'b010_0000_0000,
        S_EMIT  = 11'b100_0000_0000
    } t_state;

    // Result status codes carried on the master-side tuser.
    localparam logic STATUS_VERTEX  = 1'b0;
    localparam logic STATUS_TOO_FEW = 1'b1;

endpackage

// ----- rtl/chgw_ram.sv -----
module chgw_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- rtl/convex_hull_gift_wrap.sv -----
// Points are taken while loading; points beyond the store size are dropped.
// After the last point: a too-few status, else a leftmost scan, then a walk from hull
// vertex to hull vertex, paced by the single point-store read port and the
// one shared multiplier that forms both cross-product terms in turn.
// Reset (i_rst_n low, synchronous) clears the controller, the point count and the output
// valid; the point store keeps its contents and is only read below the count.
module convex_hull_gift_wrap
    import chgw_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 12
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // Fields from bit 0: point_x, point_y, zero padding.
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
    input  logic                                   s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // Fields from bit 0: vertex_x, vertex_y, zero padding.
    output logic [((2*COORD_BITS+7)/8)*8-1:0]      m_axis_tdata,
    // Fields from bit 0: status.
    output logic                                   m_axis_tuser,
    output logic                                   m_axis_tlast
);

    localparam int CB = COORD_BITS;
    localparam int DW = ((2*COORD_BITS+7)/8)*8;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS+1);

    t_state r_state;

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_hull;
    logic          r_rv;
    logic [AW-1:0] r_ri;
    logic [AW-1:0] r_left;
    logic [AW-1:0] r_cur;
    logic [AW-1:0] r_cand;

    logic signed [CB-1:0] r_px, r_py, r_qx, r_qy, r_rx, r_ry;
    logic signed [CB:0]   r_a, r_b, r_c, r_d;
    logic signed [2*CB+1:0] r_pa, r_pb;

    logic                 r_out_valid;
    logic                 r_out_status;
    logic signed [CB-1:0] r_out_x, r_out_y;
    logic                 r_out_last;

    logic                 ram_we;
    logic [AW-1:0]        ram_raddr;
    logic [2*CB-1:0]      ram_rdata;
    logic signed [CB-1:0] rd_x, rd_y;
    logic                 in_acc;
    logic                 store_room;
    logic [CW-1:0]        n_total;
    logic                 out_free;
    logic                 out_load;
    logic [CW-1:0]        cur_next;
    logic                 emit_last;
    logic signed [CB:0]   mul_a, mul_b;
    logic signed [2*CB+1:0] prod;

    // Point store, x in the low half and y in the high half of each entry.
    chgw_ram #(
        .WIDTH (2*CB),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (s_axis_tdata[2*CB-1:0]),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_x = signed'(ram_rdata[CB-1:0]);
    assign rd_y = signed'(ram_rdata[2*CB-1:CB]);

    // Input handshake and store write.
    assign s_axis_tready = (r_state == S_LOAD);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign store_room    = (r_count < CW'(MAX_POINTS));
    assign ram_we        = in_acc && store_room;
    assign n_total       = store_room ? r_count + CW'(1) : r_count;

    // The first candidate follows the current point, wrapping at the point count.
    assign cur_next = (CW'(r_cur) + CW'(1) == r_n) ? '0 : CW'(r_cur) + CW'(1);

    // Read address selection for the scans.
    always_comb begin
        case (r_state)
            S_LEFT:  ram_raddr = r_i[AW-1:0];
            S_QRD:   ram_raddr = cur_next[AW-1:0];
            S_RRD:   ram_raddr = r_i[AW-1:0];
            default: ram_raddr = '0;
        endcase
    end

    // One multiplier shared by both cross-product terms.
    assign mul_a = (r_state == S_MUL1) ? r_a : r_c;
    assign mul_b = (r_state == S_MUL1) ? r_b : r_d;
    assign prod  = mul_a * mul_b;

    assign out_free  = !r_out_valid || m_axis_tready;
    assign out_load  = out_free && (r_state inside {S_FEW, S_EMIT});
    assign emit_last = (r_cand == r_left) || (r_hull + CW'(1) >= CW'(MAX_POINTS));

    // Controller and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_rv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (s_axis_tlast) begin
                            r_count <= '0;
                            r_n     <= n_total;
                            r_i     <= '0;
                            r_rv    <= 1'b0;
                            r_state <= (n_total < CW'(3)) ? S_FEW : S_LEFT;
                        end else begin
                            r_count <= ram_we ? r_count + CW'(1) : r_count;
                        end
                    end
                end
                S_FEW: begin
                    if (out_free) begin
                        r_out_status <= STATUS_TOO_FEW;
                        r_out_x      <= '0;
                        r_out_y      <= '0;
                        r_out_last   <= 1'b1;
                        r_state      <= S_LOAD;
                    end
                end
                S_LEFT: begin
                    // Issue one read a cycle and compare the data in the cycle after.
                    if (r_i != r_n) begin
                        r_i  <= r_i + CW'(1);
                        r_rv <= 1'b1;
                        r_ri <= r_i[AW-1:0];
                    end else begin
                        r_rv <= 1'b0;
                    end
                    if (r_rv && (r_ri == '0 || rd_x < r_px)) begin
                        r_px   <= rd_x;
                        r_py   <= rd_y;
                        r_left <= r_ri;
                    end
                    if (r_i == r_n && !r_rv) begin
                        r_cur   <= r_left;
                        r_hull  <= '0;
                        r_state <= S_QRD;
                    end
                end
                S_QRD: begin
                    r_cand  <= cur_next[AW-1:0];
                    r_state <= S_QWAIT;
                end
                S_QWAIT: begin
                    r_qx    <= rd_x;
                    r_qy    <= rd_y;
                    r_i     <= '0;
                    r_state <= S_RRD;
                end
                S_RRD: begin
                    r_state <= S_DIF;
                end
                S_DIF: begin
                    r_rx    <= rd_x;
                    r_ry    <= rd_y;
                    r_a     <= (CB+1)'(rd_x) - (CB+1)'(r_px);
                    r_b     <= (CB+1)'(r_qy) - (CB+1)'(r_py);
                    r_c     <= (CB+1)'(r_qx) - (CB+1)'(r_px);
                    r_d     <= (CB+1)'(rd_y) - (CB+1)'(r_py);
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_pa    <= prod;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_pb    <= prod;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    // A strictly positive cross product moves the candidate; collinear keeps it.
                    if (r_pa > r_pb) begin
                        r_cand <= r_i[AW-1:0];
                        r_qx   <= r_rx;
                        r_qy   <= r_ry;
                    end
                    r_i     <= r_i + CW'(1);
                    r_state <= (r_i == r_n - CW'(1)) ? S_EMIT : S_RRD;
                end
                S_EMIT: begin
                    // The current vertex goes out once its successor is known.
                    if (out_free) begin
                        r_out_status <= STATUS_VERTEX;
                        r_out_x      <= r_px;
                        r_out_y      <= r_py;
                        r_out_last   <= emit_last;
                        r_hull       <= r_hull + CW'(1);
                        r_px         <= r_qx;
                        r_py         <= r_qy;
                        r_cur        <= r_cand;
                        r_state      <= emit_last ? S_LOAD : S_QRD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    // Output register.
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = DW'({r_out_y, r_out_x});
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_POINTS))
        else $error("point count above store size");

    a_hull_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_hull < CW'(MAX_POINTS)))
        else $error("hull count reached cap without ending the run");

    a_scan_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RRD || r_state == S_CMP) |-> (r_i < r_n && r_n >= CW'(3)))
        else $error("scan index outside the point set");

    a_too_few_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == STATUS_TOO_FEW) |-> m_axis_tlast)
        else $error("too-few status not marked last");

    a_no_input_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD && s_axis_tvalid && s_axis_tlast) |=> (r_count == '0))
        else $error("point count not cleared at start of run");
`endif

endmodule

// ----- tb/tb_top.sv -----
module tb_top
    import chgw_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = 64;
    localparam int CRD_W       = 12;
    localparam int DATA_W      = ((2*CRD_W+7)/8)*8;
    localparam int DRAIN_CYCLES = 80;

    // One point request as it is queued for the driver.
    typedef struct {
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
        logic                    last;
    } t_point_req;

    // One hull result as the block should deliver it.
    typedef struct {
        logic                    status;
        logic signed [CRD_W-1:0] vx;
        logic signed [CRD_W-1:0] vy;
        logic                    last;
    } t_hull_result;

    logic              i_clk;
    logic              i_rst_n       = 1'b0;
    logic              s_tvalid      = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata       = '0;
    logic              s_tlast       = 1'b0;
    logic              m_tvalid;
    logic              m_tready      = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic              m_tuser;
    logic              m_tlast;

    t_point_req   point_q[$];
    t_hull_result hull_q[$];

    // Mirror of the block's point store.
    logic signed [CRD_W-1:0] mir_x[STORE_DEPTH];
    logic signed [CRD_W-1:0] mir_y[STORE_DEPTH];
    int mir_count = 0;

    int total_points  = 0;
    int points_taken  = 0;
    int error_count   = 0;
    int tx_idle_pct;
    int rx_idle_pct;

    convex_hull_gift_wrap #(
        .MAX_POINTS(STORE_DEPTH),
        .COORD_BITS(CRD_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Idle rates move through three phases as the points are taken.
    always_comb begin
        if (points_taken < total_points / 3) begin
            tx_idle_pct = 7;
            rx_idle_pct = 53;
        end else if (points_taken < (2 * total_points) / 3) begin
            tx_idle_pct = 53;
            rx_idle_pct = 7;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    end

    // True when r lies strictly to the turning side of the edge p to q.
    function automatic bit turns_away(int p, int q, int r);
        longint dxr, dyq, dxq, dyr;
        dxr = longint'(mir_x[r]) - longint'(mir_x[p]);
        dyq = longint'(mir_y[q]) - longint'(mir_y[p]);
        dxq = longint'(mir_x[q]) - longint'(mir_x[p]);
        dyr = longint'(mir_y[r]) - longint'(mir_y[p]);
        return (dxr * dyq - dxq * dyr) > 0;
    endfunction

    // Stores one accepted point and, on the last one, queues the hull it yields.
    task automatic store_point_and_wrap(t_point_req pt);
        int n, leftmost, cur, cand, emitted;
        bit done;
        t_hull_result res;
        if (mir_count < STORE_DEPTH) begin
            mir_x[mir_count] = pt.x;
            mir_y[mir_count] = pt.y;
            mir_count++;
        end
        if (!pt.last) return;
        n = mir_count;
        mir_count = 0;
        if (n < 3) begin
            res.status = STATUS_TOO_FEW;
            res.vx     = '0;
            res.vy     = '0;
            res.last   = 1'b1;
            hull_q = {hull_q, res};
            return;
        end
        leftmost = 0;
        for (int i = 1; i < n; i++)
            if (mir_x[i] < mir_x[leftmost]) leftmost = i;
        cur     = leftmost;
        emitted = 0;
        done    = 1'b0;
        while (!done) begin
            res.status = STATUS_VERTEX;
            res.vx     = mir_x[cur];
            res.vy     = mir_y[cur];
            emitted++;
            cand = (cur + 1) % n;
            for (int r = 0; r < n; r++)
                if (turns_away(cur, cand, r)) cand = r;
            cur      = cand;
            done     = (cur == leftmost) || (emitted >= STORE_DEPTH);
            res.last = done;
            hull_q = {hull_q, res};
        end
    endtask

    // Driver: when the bus is free, presents the next pending point or idles at the phase's idle rate.
    always @(posedge i_clk) begin
        t_point_req nxt;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (point_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                nxt = point_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {{(DATA_W-2*CRD_W){1'b0}}, nxt.y, nxt.x};
                s_tlast  <= nxt.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver side back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Input monitor: every accepted request feeds the predictor.
    always @(posedge i_clk) begin
        t_point_req seen;
        if (i_rst_n && s_tvalid && s_tready) begin
            seen.x    = s_tdata[CRD_W-1:0];
            seen.y    = s_tdata[2*CRD_W-1:CRD_W];
            seen.last = s_tlast;
            store_point_and_wrap(seen);
            points_taken <= points_taken + 1;
        end
    end

    // Output monitor: compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        t_hull_result want;
        logic signed [CRD_W-1:0] got_x, got_y;
        if (i_rst_n && m_tvalid && m_tready) begin
            got_x = m_tdata[CRD_W-1:0];
            got_y = m_tdata[2*CRD_W-1:CRD_W];
            if (hull_q.size() == 0) begin
                $display("%0t: unexpected result status=%0b x=%0d y=%0d last=%0b",
                         $time, m_tuser, got_x, got_y, m_tlast);
                error_count++;
            end else begin
                want = hull_q.pop_front();
                if (m_tuser !== want.status) begin
                    $display("%0t: status expected %0b actual %0b",
                             $time, want.status, m_tuser);
                    error_count++;
                end
                if (got_x !== want.vx) begin
                    $display("%0t: vertex_x expected %0d actual %0d", $time, want.vx, got_x);
                    error_count++;
                end
                if (got_y !== want.vy) begin
                    $display("%0t: vertex_y expected %0d actual %0d", $time, want.vy, got_y);
                    error_count++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: last_vertex expected %0b actual %0b",
                             $time, want.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    task automatic add_point(int x, int y, bit last);
        t_point_req pt;
        pt.x    = CRD_W'(x);
        pt.y    = CRD_W'(y);
        pt.last = last;
        point_q = {point_q, pt};
    endtask

    // Coordinate drawn in one of three flavors: full range, tight cluster, or extremes.
    function automatic int pick_coord(int flavor);
        int sel;
        case (flavor)
            0: return $urandom_range(4095) - 2048;
            1: return $urandom_range(6) - 3;
            default: begin
                sel = $urandom_range(3);
                case (sel)
                    0: return -2048;
                    1: return -1;
                    2: return 0;
                    default: return 2047;
                endcase
            end
        endcase
    endfunction

    task automatic add_random_set(int n, int flavor);
        for (int i = 0; i < n; i++)
            add_point(pick_coord(flavor), pick_coord(flavor), i == n - 1);
    endtask

    initial begin
        int n, pick, flav, same_x, same_y;

        // Directed: too few points, one and two.
        add_point(-2048, 2047, 1'b1);
        add_point(2047, -2048, 1'b0);
        add_point(-2048, -2048, 1'b1);
        // Triangle on the coordinate extremes.
        add_point(-2048, -2048, 1'b0);
        add_point(2047, -2048, 1'b0);
        add_point(0, 2047, 1'b1);
        // Square with a collinear edge point, a duplicate corner and an inner point.
        add_point(2047, 2047, 1'b0);
        add_point(-2048, 2047, 1'b0);
        add_point(-2048, -2048, 1'b0);
        add_point(2047, -2048, 1'b0);
        add_point(0, 2047, 1'b0);
        add_point(2047, 2047, 1'b0);
        add_point(0, 0, 1'b1);
        // All points on one line.
        add_point(-5, 0, 1'b0);
        add_point(0, 0, 1'b0);
        add_point(5, 0, 1'b1);
        // Several points share the smallest x.
        add_point(-100, 5, 1'b0);
        add_point(-100, -5, 1'b0);
        add_point(50, 0, 1'b0);
        add_point(-100, 0, 1'b1);

        // Store overflow: the extra points are dropped, the last one still starts the run.
        add_random_set(66, $urandom_range(1));
        // A full store of identical points walks every index up to the cap.
        same_x = pick_coord(0);
        same_y = pick_coord(0);
        for (int i = 0; i < STORE_DEPTH; i++)
            add_point(same_x, same_y, i == STORE_DEPTH - 1);

        // Random sets, mostly small hulls of random shape.
        while (point_q.size() < 300) begin
            pick = $urandom_range(99);
            flav = $urandom_range(2);
            if (pick < 10)
                n = $urandom_range(1, 2);
            else if (pick < 15)
                n = $urandom_range(11, 40);
            else
                n = $urandom_range(3, 10);
            add_random_set(n, flav);
        end
        // A little noise: a closing random set of three to six full-range points.
        add_random_set($urandom_range(3, 6), 0);
        total_points = point_q.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (point_q.size() > 0 || s_tvalid || hull_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog for a hung block.
    initial begin
        #4ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/chgw_pkg.sv
rtl/chgw_ram.sv
rtl/convex_hull_gift_wrap.sv
tb/tb_top.sv
